// ===== rtl/wpf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared types, constants and the arctangent table of the waypoint follower.
// ----------------------------------------------------------------------------
package wpf_pkg;

    // waypoint queue depth and index widths
    localparam int PATH_DEPTH   = 16;
    localparam int IDX_W        = $clog2(PATH_DEPTH);
    localparam int CNT_W        = $clog2(PATH_DEPTH + 1);
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // datapath widths
    localparam int COORD_W   = 32;
    localparam int MS_W      = 16;
    localparam int SPEED_W   = 24;
    localparam int HEAD_W    = 16;
    localparam int PCOUNT_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int VEC_W     = 60;
    localparam int ANG_W     = 28;
    localparam int MUL_W     = DIFF_W;
    localparam int PROD_W    = 2 * MUL_W;

    // fixed-point constants
    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam int HALF_TURN  = 11796480;
    localparam int HEAD_LIMIT = 23040;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT = 1'd1;

    // input modes
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_PLACE = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_TICK,
        OP_PLACE,
        OP_NOP
    } t_op;

    // classified request handed from front to back
    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [MS_W-1:0]            ms;
    } t_cmd;

    // arctangent of 2^-i in degrees * 65536
    function automatic logic signed [ANG_W-1:0] atan_deg16(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 28'sd2949120;
            5'd1:    v = 28'sd1740967;
            5'd2:    v = 28'sd919879;
            5'd3:    v = 28'sd466945;
            5'd4:    v = 28'sd234379;
            5'd5:    v = 28'sd117304;
            5'd6:    v = 28'sd58666;
            5'd7:    v = 28'sd29335;
            5'd8:    v = 28'sd14668;
            5'd9:    v = 28'sd7334;
            5'd10:   v = 28'sd3667;
            5'd11:   v = 28'sd1833;
            5'd12:   v = 28'sd917;
            5'd13:   v = 28'sd458;
            5'd14:   v = 28'sd229;
            5'd15:   v = 28'sd115;
            5'd16:   v = 28'sd57;
            5'd17:   v = 28'sd29;
            5'd18:   v = 28'sd14;
            5'd19:   v = 28'sd7;
            5'd20:   v = 28'sd4;
            5'd21:   v = 28'sd2;
            5'd22:   v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/wpf_if.sv =====
// ----------------------------------------------------------------------------
// wpf channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wpf_in_if import wpf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic [MS_W-1:0]            ms_passed;

    modport source (output valid, mode, coord_x, coord_y, ms_passed, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, ms_passed, output ready);
endinterface

interface wpf_out_if import wpf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [HEAD_W-1:0]   heading_deg;
    logic                       waypoint_reached;
    logic [PCOUNT_W-1:0]        path_count;
    logic                       push_dropped;

    modport source (output valid, pos_x, pos_y, heading_deg, waypoint_reached,
                    path_count, push_dropped, input ready);
    modport sink   (input valid, pos_x, pos_y, heading_deg, waypoint_reached,
                    path_count, push_dropped, output ready);
endinterface

interface wpf_cfg_if import wpf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wpf_front.sv =====
// ----------------------------------------------------------------------------
// wpf_front
// Accepts requests, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module wpf_front import wpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wpf_in_if.sink      i_in,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    localparam int Q_DEPTH = 2;

    t_cmd       r_q [Q_DEPTH];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // classify the request
    always_comb begin
        w_cmd.x  = i_in.coord_x;
        w_cmd.y  = i_in.coord_y;
        w_cmd.ms = i_in.ms_passed;
        unique case (i_in.mode)
            MODE_PUSH:  w_cmd.op = OP_PUSH;
            MODE_TICK:  w_cmd.op = OP_TICK;
            MODE_PLACE: w_cmd.op = OP_PLACE;
            default:    w_cmd.op = OP_NOP;
        endcase
    end

    assign i_in.ready  = (r_cnt != 2'(Q_DEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // queue pointers
    always_comb begin
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = w_pop  ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

// ===== rtl/wpf_back.sv =====
// ----------------------------------------------------------------------------
// wpf_back
// Executes queued requests: waypoint store, position, heading and CORDIC.
// ----------------------------------------------------------------------------
module wpf_back import wpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    wpf_cfg_if.sink     i_cfg,
    wpf_out_if.source   o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CORD = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [STEP_W-1:0] LAST_IT = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] MUL_END = STEP_W'(3);

    // state
    logic [2:0]                 r_state;
    logic [STEP_W-1:0]          r_cnt;
    logic [SPEED_W-1:0]         r_speed;
    logic                       r_orient;
    logic signed [COORD_W-1:0]  r_px, r_py;
    logic signed [HEAD_W-1:0]   r_head_deg;
    logic [IDX_W-1:0]           r_head;
    logic [CNT_W-1:0]           r_count;

    // waypoint memory
    logic [2*COORD_W-1:0]       mem [PATH_DEPTH];
    logic [2*COORD_W-1:0]       r_rd;
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;

    // tick datapath
    logic [MS_W-1:0]            r_ms;
    logic signed [COORD_W-1:0]  r_tx, r_ty;
    logic signed [DIFF_W-1:0]   r_dx, r_dy;
    logic [COORD_W-1:0]         r_step;
    logic [PROD_W-2:0]          r_sqx, r_sqy, r_sqs;
    logic signed [VEC_W-1:0]    r_vx, r_vy, r_rx, r_ry;
    logic signed [ANG_W-1:0]    r_z;
    logic                       r_flip;
    logic                       r_within;
    logic signed [COORD_W-1:0]  r_nx, r_ny;
    logic signed [HEAD_W-1:0]   r_nh;

    // result register
    logic                       r_ovalid;
    logic signed [COORD_W-1:0]  r_ox, r_oy;
    logic signed [HEAD_W-1:0]   r_oh;
    logic                       r_oreach, r_odrop;
    logic [CNT_W-1:0]           r_ocnt;

    logic                       w_out_free;
    logic                       w_take;
    logic                       w_set_out;
    logic [IDX_W:0]             w_tail_sum;
    logic [IDX_W-1:0]           w_head_nx;
    logic [MUL_W-1:0]           w_ma, w_mb;
    logic [PROD_W-1:0]          w_prod;
    logic [DIFF_W-1:0]          w_ax, w_ay;
    logic signed [VEC_W-1:0]    w_xs, w_ys, w_rxs, w_rys;
    logic                       w_dir;
    logic signed [VEC_W-1:0]    w_rxf, w_ryf;
    logic signed [VEC_W-25:0]   w_mx, w_my;
    logic signed [VEC_W-23:0]   w_sx, w_sy;
    logic signed [ANG_W-10:0]   w_h;
    logic signed [VEC_W-1:0]    w_vx0, w_vy0;
    logic [PROD_W:0]            w_sumsq;

    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign w_take      = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign o_cmd_pop   = w_take;

    // a result is loaded for every request but a tick on a non-empty path,
    // and when a tick retires
    assign w_set_out = (w_take && !(i_cmd.op == OP_TICK && r_count != '0))
                    || ((r_state == S_DONE) && w_out_free);

    // ring addresses without assuming a power-of-two depth
    always_comb begin
        w_tail_sum = (IDX_W+1)'(r_head) + (IDX_W+1)'(r_count);
        if (w_tail_sum >= (IDX_W+1)'(PATH_DEPTH)) begin
            w_tail_sum = w_tail_sum - (IDX_W+1)'(PATH_DEPTH);
        end
        w_waddr   = w_tail_sum[IDX_W-1:0];
        w_head_nx = (r_head == IDX_W'(PATH_DEPTH - 1)) ? '0 : r_head + 1'b1;
        w_we      = w_take && (i_cmd.op == OP_PUSH) && (r_count < CNT_W'(PATH_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= {i_cmd.x, i_cmd.y};
        end
        r_rd <= mem[r_head];
    end

    // shared multiplier: squares, step squared, step times inverse gain
    always_comb begin
        w_ax = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
        w_ay = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
        case (r_cnt[1:0])
            2'd0:    begin w_ma = w_ax; w_mb = w_ax; end
            2'd1:    begin w_ma = w_ay; w_mb = w_ay; end
            2'd2:    begin w_ma = MUL_W'(r_step); w_mb = MUL_W'(r_step); end
            default: begin w_ma = MUL_W'(r_step); w_mb = MUL_W'(INV_GAIN); end
        endcase
        w_prod = w_ma * w_mb;
    end

    // cordic step: vectoring and rotation share the direction
    always_comb begin
        w_xs  = r_vx >>> r_cnt;
        w_ys  = r_vy >>> r_cnt;
        w_rxs = r_rx >>> r_cnt;
        w_rys = r_ry >>> r_cnt;
        w_dir = !r_vy[VEC_W-1];
        w_vx0 = VEC_W'(r_dx) <<< 24;
        w_vy0 = VEC_W'(r_dy) <<< 24;
        w_sumsq = (PROD_W+1)'(r_sqx) + (PROD_W+1)'(r_sqy);
    end

    // move rounding, saturation and heading
    always_comb begin
        w_rxf = r_flip ? -r_rx : r_rx;
        w_ryf = r_flip ? -r_ry : r_ry;
        w_mx  = (VEC_W-24)'((w_rxf + VEC_W'(25'sd8388608)) >>> 24);
        w_my  = (VEC_W-24)'((w_ryf + VEC_W'(25'sd8388608)) >>> 24);
        w_sx  = (VEC_W-22)'(r_px) + (VEC_W-22)'(w_mx);
        w_sy  = (VEC_W-22)'(r_py) + (VEC_W-22)'(w_my);
        w_h   = (ANG_W-9)'((r_z + ANG_W'(256)) >>> 9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_speed    <= SPEED_W'(65536);
            r_orient   <= 1'b1;
            r_px       <= '0;
            r_py       <= '0;
            r_head_deg <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_SPEED:  r_speed  <= i_cfg.data;
                    REG_ORIENT: r_orient <= i_cfg.data[0];
                    default:    ;
                endcase
            end

            // result valid: set on a new result, cleared once taken
            r_ovalid <= w_set_out || (r_ovalid && !o_out.ready);

            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_oh     <= r_head_deg;
                        r_oreach <= 1'b0;
                        r_ms     <= i_cmd.ms;
                        r_odrop  <= (i_cmd.op == OP_PUSH) && !w_we;
                        if (i_cmd.op == OP_PLACE) begin
                            r_px <= i_cmd.x;
                            r_py <= i_cmd.y;
                            r_ox <= i_cmd.x;
                            r_oy <= i_cmd.y;
                        end else begin
                            r_ox <= r_px;
                            r_oy <= r_py;
                        end
                        if (w_we) begin
                            r_count <= r_count + 1'b1;
                            r_ocnt  <= r_count + 1'b1;
                        end else begin
                            r_ocnt  <= r_count;
                        end
                        if (i_cmd.op == OP_TICK && r_count != '0) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_tx   <= r_rd[2*COORD_W-1:COORD_W];
                    r_ty   <= r_rd[COORD_W-1:0];
                    r_dx   <= DIFF_W'($signed(r_rd[2*COORD_W-1:COORD_W])) - DIFF_W'(r_px);
                    r_dy   <= DIFF_W'($signed(r_rd[COORD_W-1:0])) - DIFF_W'(r_py);
                    r_step <= COORD_W'(((MS_W+SPEED_W)'(r_ms)
                                        * (MS_W+SPEED_W)'(r_speed)) >> 8);
                    r_cnt  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    case (r_cnt[1:0])
                        2'd0: begin
                            r_sqx  <= w_prod[PROD_W-2:0];
                            r_flip <= r_dx[DIFF_W-1];
                            r_vx   <= r_dx[DIFF_W-1] ? -w_vx0 : w_vx0;
                            r_vy   <= r_dx[DIFF_W-1] ? -w_vy0 : w_vy0;
                            if (!r_dx[DIFF_W-1]) begin
                                r_z <= '0;
                            end else if (!r_dy[DIFF_W-1]) begin
                                r_z <= ANG_W'(HALF_TURN);
                            end else begin
                                r_z <= -ANG_W'(HALF_TURN);
                            end
                        end
                        2'd1:    r_sqy <= w_prod[PROD_W-2:0];
                        2'd2:    r_sqs <= w_prod[PROD_W-2:0];
                        default: begin
                            r_rx <= VEC_W'(w_prod >> 6);
                            r_ry <= '0;
                        end
                    endcase
                    if (r_cnt == MUL_END) begin
                        r_cnt   <= '0;
                        r_state <= S_CORD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CORD: begin
                    if (r_cnt == '0) begin
                        r_within <= (w_sumsq <= (PROD_W+1)'(r_sqs));
                    end
                    if (w_dir) begin
                        r_vx <= r_vx + w_ys;
                        r_vy <= r_vy - w_xs;
                        r_z  <= r_z + atan_deg16(5'(r_cnt));
                        r_rx <= r_rx - w_rys;
                        r_ry <= r_ry + w_rxs;
                    end else begin
                        r_vx <= r_vx - w_ys;
                        r_vy <= r_vy + w_xs;
                        r_z  <= r_z - atan_deg16(5'(r_cnt));
                        r_rx <= r_rx + w_rys;
                        r_ry <= r_ry - w_rxs;
                    end
                    if (r_cnt == LAST_IT) begin
                        r_state <= S_MOVE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MOVE: begin
                    if (r_within) begin
                        r_nx <= r_tx;
                        r_ny <= r_ty;
                    end else begin
                        if (w_sx > (VEC_W-22)'(32'sh7FFFFFFF)) begin
                            r_nx <= 32'sh7FFFFFFF;
                        end else if (w_sx < -(VEC_W-22)'(33'sh80000000)) begin
                            r_nx <= 32'sh80000000;
                        end else begin
                            r_nx <= COORD_W'(w_sx);
                        end
                        if (w_sy > (VEC_W-22)'(32'sh7FFFFFFF)) begin
                            r_ny <= 32'sh7FFFFFFF;
                        end else if (w_sy < -(VEC_W-22)'(33'sh80000000)) begin
                            r_ny <= 32'sh80000000;
                        end else begin
                            r_ny <= COORD_W'(w_sy);
                        end
                    end
                    if (r_orient && (r_dx != '0 || r_dy != '0)) begin
                        if (w_h > (ANG_W-9)'(HEAD_LIMIT)) begin
                            r_nh <= HEAD_W'(HEAD_LIMIT);
                        end else if (w_h < -(ANG_W-9)'(HEAD_LIMIT)) begin
                            r_nh <= -HEAD_W'(HEAD_LIMIT);
                        end else begin
                            r_nh <= HEAD_W'(w_h);
                        end
                    end else begin
                        r_nh <= r_head_deg;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_px       <= r_nx;
                        r_py       <= r_ny;
                        r_head_deg <= r_nh;
                        r_ox       <= r_nx;
                        r_oy       <= r_ny;
                        r_oh       <= r_nh;
                        r_odrop    <= 1'b0;
                        if (r_nx == r_tx && r_ny == r_ty) begin
                            r_head   <= w_head_nx;
                            r_count  <= r_count - 1'b1;
                            r_ocnt   <= r_count - 1'b1;
                            r_oreach <= 1'b1;
                        end else begin
                            r_ocnt   <= r_count;
                            r_oreach <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.pos_x            = r_ox;
    assign o_out.pos_y            = r_oy;
    assign o_out.heading_deg      = r_oh;
    assign o_out.waypoint_reached = r_oreach;
    assign o_out.path_count       = PCOUNT_W'(r_ocnt);
    assign o_out.push_dropped     = r_odrop;

endmodule

// ===== rtl/waypoint_path_follower.sv =====
// ----------------------------------------------------------------------------
// waypoint_path_follower
// Waypoint queue with a fixed-point position, heading and CORDIC move unit.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time, one result
// per request. Push, place and undefined modes, and a tick on an empty path,
// load their result when the back end takes them from the queue. A tick on a
// non-empty path passes the request queue, the waypoint memory read, the
// differences and the step (S_LOAD), four steps of a shared 33x33 multiplier
// (both squares, the step squared, the gain-corrected step), CORDIC_STEPS
// CORDIC iterations, rounding and saturation (S_MOVE) and retirement (S_DONE),
// which waits for a free result register. The CORDIC loop sets the tick rate.
// Configuration writes are always ready and take effect at once.
module waypoint_path_follower import wpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wpf_in_if.sink      i_in,
    wpf_cfg_if.sink     i_cfg,
    wpf_out_if.source   o_out
);

    logic   w_cmd_valid;
    t_cmd   w_cmd;
    logic   w_cmd_pop;

    // request decode and queue
    wpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // execution unit
    wpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // a result never both reaches a waypoint and drops a push
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.waypoint_reached && o_out.push_dropped))
        else $error("reached and dropped flags both set");

    // a dropped push only happens on a full path
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.push_dropped) |->
            (o_out.path_count == PCOUNT_W'(PATH_DEPTH)))
        else $error("push dropped with room left");

    // heading stays within half a turn
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.heading_deg <= HEAD_W'(HEAD_LIMIT)
                         && o_out.heading_deg >= -HEAD_W'(HEAD_LIMIT)))
        else $error("heading out of range");

    // the queue hands nothing to the back end while empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("queue popped while empty");
`endif

endmodule
